// File: hw/rtl/atrp_pkg.sv
package atrp_pkg;

    localparam int DEF_MAX_LINES    = 16;
    localparam int DEF_MAX_LINE_LEN = 128;

    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int SLINE_W = 4;
    localparam int SCOL_W  = 7;
    localparam int LDONE_W = 5;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h4f;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4b;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_PR_LO = 8'd32;
    localparam logic [BYTE_W-1:0] CH_PR_HI = 8'd126;

    typedef enum logic [STAT_W-1:0] {
        STAT_NOT_READY = 2'd0,
        STAT_DONE      = 2'd1,
        STAT_ERROR     = 2'd2
    } status_t;

    typedef enum logic [17:0] {
        ST_WAIT_CR   = 18'h00001,
        ST_HDR_LF    = 18'h00002,
        ST_BODY      = 18'h00004,
        ST_OK_O      = 18'h00008,
        ST_ERR_E     = 18'h00010,
        ST_TEXT_1ST  = 18'h00020,
        ST_OK_K      = 18'h00040,
        ST_OK_LF     = 18'h00080,
        ST_ERR_R1    = 18'h00100,
        ST_ERR_R2    = 18'h00200,
        ST_ERR_O     = 18'h00400,
        ST_ERR_R3    = 18'h00800,
        ST_ERR_LF    = 18'h01000,
        ST_TEXT      = 18'h02000,
        ST_LINE_LF   = 18'h04000,
        ST_LINE_END  = 18'h08000,
        ST_TAIL_LF   = 18'h10000,
        ST_TAIL      = 18'h20000
    } state_t;

    function automatic logic is_text(input logic [BYTE_W-1:0] c);
        return (c >= CH_PR_LO) && (c <= CH_PR_HI);
    endfunction

endpackage

// File: hw/rtl/atrp_in_if.sv
interface atrp_in_if;
    import atrp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/atrp_out_if.sv
interface atrp_out_if;
    import atrp_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic               store_valid;
    logic [BYTE_W-1:0]  store_char;
    logic [SLINE_W-1:0] store_line;
    logic [SCOL_W-1:0]  store_col;
    logic [LDONE_W-1:0] lines_done;

    modport source (output valid, output status, output store_valid, output store_char,
                    output store_line, output store_col, output lines_done, input ready);
    modport sink   (input valid, input status, input store_valid, input store_char,
                    input store_line, input store_col, input lines_done, output ready);
endinterface

// File: hw/rtl/at_response_parser_top.sv
// Modem AT response checker, one received byte per transaction.
// in_ch carries rx_byte; out_ch returns one result transaction per input byte:
// status (not ready / complete / grammar error), a text-store write strobe with
// character, line and column for an external line store, and lines_done.
// Latency: the result is registered and valid in the cycle after the input
// transaction. Throughput: one byte per cycle while the receiver does not stall,
// set by the update of the parse state and the line/column counters on every byte.
// A held result does not block a new byte while out_ch.ready is high in the
// same cycle; if the receiver stalls, in_ch.ready drops until the held
// result is taken. No result is dropped or repeated.
// On a grammar error the parse state and counters are left as they were.
// Line counter: cleared only at reset, never between responses; saturates
// at MAX_LINES. Column counter: also cleared as a new text line opens.
// Reset (rst_n low, asynchronous) returns to waiting for CR with both
// counters at zero and no result pending.
module at_response_parser_top
#(
    parameter int MAX_LINES    = atrp_pkg::DEF_MAX_LINES,
    parameter int MAX_LINE_LEN = atrp_pkg::DEF_MAX_LINE_LEN
)
(
    input  logic              clk,
    input  logic              rst_n,
    atrp_in_if.sink           in_ch,
    atrp_out_if.source        out_ch
);
    import atrp_pkg::*;

    localparam int LINE_W = $clog2(MAX_LINES + 1);
    localparam int COL_W  = $clog2(MAX_LINE_LEN + 1);

    state_t              state_reg, state_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [COL_W-1:0]    col_reg, col_next;

    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic                store_reg, store_next;
    logic [BYTE_W-1:0]   char_reg, char_next;
    logic [SLINE_W-1:0]  sline_reg, sline_next;
    logic [SCOL_W-1:0]   scol_reg, scol_next;
    logic [LDONE_W-1:0]  ldone_reg, ldone_next;

    logic                accept;
    logic [BYTE_W-1:0]   c;
    logic                in_bounds;
    logic                line_open;
    logic                err;
    logic                store;
    state_t              nxt;
    logic [LINE_W-1:0]   line_upd;
    logic [COL_W-1:0]    col_upd;
    logic [7:0]          line_ext;
    logic [7:0]          col_ext;
    logic [7:0]          line_upd_ext;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign c           = in_ch.rx_byte;

    assign line_open = line_reg < LINE_W'(MAX_LINES);
    assign in_bounds = line_open && (col_reg < COL_W'(MAX_LINE_LEN));

    always_comb
    begin
        nxt      = state_reg;
        err      = 1'b0;
        store    = 1'b0;
        line_upd = line_reg;
        col_upd  = col_reg;
        status_next = STAT_NOT_READY;
        unique case (state_reg)
            ST_WAIT_CR:
            begin
                if (c == CH_CR) nxt = ST_HDR_LF;
            end
            ST_HDR_LF:
            begin
                if (c == CH_LF) nxt = ST_BODY; else err = 1'b1;
            end
            ST_BODY, ST_TEXT_1ST:
            begin
                if (state_reg == ST_BODY && c == CH_O) nxt = ST_OK_O;
                else if (state_reg == ST_BODY && c == CH_E) nxt = ST_ERR_E;
                else if (state_reg == ST_BODY && c == CH_PLUS) nxt = ST_TEXT_1ST;
                else if (is_text(c))
                begin
                    if (in_bounds)
                    begin
                        store   = 1'b1;
                        col_upd = col_reg + 1'b1;
                    end
                    nxt = ST_TEXT;
                end
                else err = 1'b1;
            end
            ST_OK_O:
            begin
                if (c == CH_K) nxt = ST_OK_K; else err = 1'b1;
            end
            ST_ERR_E:
            begin
                if (c == CH_R) nxt = ST_ERR_R1; else err = 1'b1;
            end
            ST_OK_K:
            begin
                if (c == CH_CR) nxt = ST_OK_LF; else err = 1'b1;
            end
            ST_OK_LF, ST_ERR_LF:
            begin
                if (c == CH_LF)
                begin
                    nxt         = ST_WAIT_CR;
                    status_next = STAT_DONE;
                end
                else err = 1'b1;
            end
            ST_ERR_R1:
            begin
                if (c == CH_R) nxt = ST_ERR_R2; else err = 1'b1;
            end
            ST_ERR_R2:
            begin
                if (c == CH_O) nxt = ST_ERR_O; else err = 1'b1;
            end
            ST_ERR_O:
            begin
                if (c == CH_R) nxt = ST_ERR_R3; else err = 1'b1;
            end
            ST_ERR_R3:
            begin
                if (c == CH_CR) nxt = ST_ERR_LF; else err = 1'b1;
            end
            ST_TEXT:
            begin
                if (is_text(c))
                begin
                    if (in_bounds)
                    begin
                        store   = 1'b1;
                        col_upd = col_reg + 1'b1;
                    end
                end
                else if (c == CH_CR) nxt = ST_LINE_LF;
                else err = 1'b1;
            end
            ST_LINE_LF:
            begin
                if (c == CH_LF)
                begin
                    if (line_open) line_upd = line_reg + 1'b1;
                    nxt = ST_LINE_END;
                end
                else err = 1'b1;
            end
            ST_LINE_END:
            begin
                // text past the limits is swallowed without leaving this state
                if (is_text(c))
                begin
                    if (in_bounds)
                    begin
                        col_upd = '0;
                        nxt     = ST_TEXT_1ST;
                    end
                end
                else if (c == CH_CR) nxt = ST_TAIL_LF;
                else err = 1'b1;
            end
            ST_TAIL_LF:
            begin
                if (c == CH_LF) nxt = ST_TAIL; else err = 1'b1;
            end
            ST_TAIL:
            begin
                if (c == CH_E) nxt = ST_ERR_E;
                else if (c == CH_O) nxt = ST_OK_O;
                else err = 1'b1;
            end
            default:
            begin
                nxt = ST_WAIT_CR;
            end
        endcase

        if (err)
        begin
            status_next = STAT_ERROR;
            state_next  = state_reg;
            line_next   = line_reg;
            col_next    = col_reg;
        end
        else
        begin
            state_next = nxt;
            line_next  = line_upd;
            col_next   = col_upd;
        end
    end

    assign line_ext     = 8'(line_reg);
    assign col_ext      = 8'(col_reg);
    assign line_upd_ext = 8'(line_next);

    assign store_next = store;
    assign char_next  = store ? c : '0;
    assign sline_next = store ? line_ext[SLINE_W-1:0] : '0;
    assign scol_next  = store ? col_ext[SCOL_W-1:0] : '0;
    assign ldone_next = line_upd_ext[LDONE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT_CR;
            line_reg      <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
            end
            if (accept) out_valid_reg <= 1'b1;
            else if (out_ch.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            store_reg  <= store_next;
            char_reg   <= char_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            ldone_reg  <= ldone_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.store_valid = store_reg;
    assign out_ch.store_char  = char_reg;
    assign out_ch.store_line  = sline_reg;
    assign out_ch.store_col   = scol_reg;
    assign out_ch.lines_done  = ldone_reg;

endmodule

// File: verif/tb_at_response_parser_top.sv
`timescale 1ns / 1ps

module tb_at_response_parser_top;
    import atrp_pkg::*;

    localparam int MAX_LINES    = DEF_MAX_LINES;
    localparam int MAX_LINE_LEN = DEF_MAX_LINE_LEN;

    typedef struct packed {
        status_t            status;
        logic               store_valid;
        logic [BYTE_W-1:0]  store_char;
        logic [SLINE_W-1:0] store_line;
        logic [SCOL_W-1:0]  store_col;
        logic [LDONE_W-1:0] lines_done;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    atrp_in_if  in_ch ();
    atrp_out_if out_ch ();

    at_response_parser_top #(
        .MAX_LINES    (MAX_LINES),
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // parser model state
    state_t       parse_st = ST_WAIT_CR;
    logic [4:0]   line_cnt = '0;
    logic [7:0]   col_cnt  = '0;

    parse_result_t results_due[$];
    int           bytes_sent = 0;
    int           mismatches = 0;
    int           src_idle   = 0;
    int           rcv_stall  = 0;
    logic         rcv_hold   = 1'b0;

    function automatic logic printable(input logic [BYTE_W-1:0] c);
        return c >= CH_PR_LO && c <= CH_PR_HI;
    endfunction

    function automatic parse_result_t parse_byte(input logic [BYTE_W-1:0] c);
        parse_result_t r;
        state_t        nxt;
        logic          bad;
        logic          take;
        logic          room;
        r    = '0;
        nxt  = parse_st;
        bad  = 1'b0;
        take = 1'b0;
        room = (line_cnt < MAX_LINES) && (col_cnt < MAX_LINE_LEN);
        case (parse_st)
            ST_WAIT_CR:
                if (c == CH_CR)
                    nxt = ST_HDR_LF;
            ST_HDR_LF:
                if (c == CH_LF)
                    nxt = ST_BODY;
                else
                    bad = 1'b1;
            ST_BODY, ST_TEXT_1ST:
                if (parse_st == ST_BODY && c == CH_O)
                    nxt = ST_OK_O;
                else if (parse_st == ST_BODY && c == CH_E)
                    nxt = ST_ERR_E;
                else if (parse_st == ST_BODY && c == CH_PLUS)
                    nxt = ST_TEXT_1ST;
                else if (printable(c))
                begin
                    take = 1'b1;
                    nxt  = ST_TEXT;
                end
                else
                    bad = 1'b1;
            ST_OK_O:
                if (c == CH_K) nxt = ST_OK_K; else bad = 1'b1;
            ST_ERR_E:
                if (c == CH_R) nxt = ST_ERR_R1; else bad = 1'b1;
            ST_OK_K:
                if (c == CH_CR) nxt = ST_OK_LF; else bad = 1'b1;
            ST_OK_LF, ST_ERR_LF:
                if (c == CH_LF)
                begin
                    nxt      = ST_WAIT_CR;
                    r.status = STAT_DONE;
                end
                else
                    bad = 1'b1;
            ST_ERR_R1:
                if (c == CH_R) nxt = ST_ERR_R2; else bad = 1'b1;
            ST_ERR_R2:
                if (c == CH_O) nxt = ST_ERR_O; else bad = 1'b1;
            ST_ERR_O:
                if (c == CH_R) nxt = ST_ERR_R3; else bad = 1'b1;
            ST_ERR_R3:
                if (c == CH_CR) nxt = ST_ERR_LF; else bad = 1'b1;
            ST_TEXT:
                if (printable(c))
                    take = 1'b1;
                else if (c == CH_CR)
                    nxt = ST_LINE_LF;
                else
                    bad = 1'b1;
            ST_LINE_LF:
                if (c == CH_LF)
                begin
                    if (line_cnt < MAX_LINES)
                        line_cnt++;
                    nxt = ST_LINE_END;
                end
                else
                    bad = 1'b1;
            ST_LINE_END:
                // a text byte here opens the next line and is swallowed;
                // out of bounds it is dropped and the state holds
                if (printable(c))
                begin
                    if (room)
                    begin
                        col_cnt = '0;
                        nxt     = ST_TEXT_1ST;
                    end
                end
                else if (c == CH_CR)
                    nxt = ST_TAIL_LF;
                else
                    bad = 1'b1;
            ST_TAIL_LF:
                if (c == CH_LF) nxt = ST_TAIL; else bad = 1'b1;
            ST_TAIL:
                if (c == CH_E)
                    nxt = ST_ERR_E;
                else if (c == CH_O)
                    nxt = ST_OK_O;
                else
                    bad = 1'b1;
            default:
                nxt = ST_WAIT_CR;
        endcase
        if (take && room)
        begin
            r.store_valid = 1'b1;
            r.store_char  = c;
            r.store_line  = line_cnt[SLINE_W-1:0];
            r.store_col   = col_cnt[SCOL_W-1:0];
            col_cnt++;
        end
        // grammar error leaves the state alone
        if (bad)
            r.status = STAT_ERROR;
        else
            parse_st = nxt;
        r.lines_done = line_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : result_check
        parse_result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (results_due.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = results_due.pop_front();
                check_field("status", 8'(out_ch.status), 8'(want.status));
                check_field("store_valid", 8'(out_ch.store_valid),
                            8'(want.store_valid));
                check_field("store_char", out_ch.store_char, want.store_char);
                check_field("store_line", 8'(out_ch.store_line),
                            8'(want.store_line));
                check_field("store_col", 8'(out_ch.store_col), 8'(want.store_col));
                check_field("lines_done", 8'(out_ch.lines_done),
                            8'(want.lines_done));
            end
        end
        out_ch.ready <= !rcv_hold && ($urandom_range(99) >= rcv_stall);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        results_due.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    // occasionally slip a random byte in front of a well-formed one
    task automatic send_framed(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < 3)
            send_byte(8'($urandom_range(255)));
        send_byte(b);
    endtask

    function automatic logic [BYTE_W-1:0] rand_text();
        return 8'($urandom_range(CH_PR_HI, CH_PR_LO));
    endfunction

    task automatic send_response();
        int n_lines;
        int len;
        n_lines = $urandom_range(3);
        send_framed(CH_CR);
        send_framed(CH_LF);
        for (int i = 0; i < n_lines; i++)
        begin
            if (i > 0)
                send_framed(rand_text());
            if (i == 0)
                len = $urandom_range(1, 3);
            else if ($urandom_range(9) == 0)
                len = $urandom_range(20, 100);
            else
                len = $urandom_range(1, 6);
            // last storable line runs past the column limit
            if (i > 0 && line_cnt == MAX_LINES - 1)
                len = MAX_LINE_LEN + 2;
            repeat (len)
                send_framed(rand_text());
            send_framed(CH_CR);
            send_framed(CH_LF);
        end
        if (n_lines > 0)
        begin
            send_framed(CH_CR);
            send_framed(CH_LF);
        end
        if ($urandom_range(1))
        begin
            send_framed(CH_O);
            send_framed(CH_K);
        end
        else
        begin
            send_framed(CH_E);
            send_framed(CH_R);
            send_framed(CH_R);
            send_framed(CH_O);
            send_framed(CH_R);
        end
        send_framed(CH_CR);
        send_framed(CH_LF);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_noise();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CH_K);
    endtask

    task automatic test_ok_response();
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_O);
        send_byte(8'h00);
        send_byte(CH_K);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_text_lines();
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_PLUS);
        send_byte(CH_PR_HI);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte("x");
        send_byte(CH_PR_LO);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_E);
        send_byte(CH_R);
        send_byte(CH_R);
        send_byte(CH_O);
        send_byte(CH_R);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_random_traffic(input int n_bytes, input int idle_pct,
                                       input int stall_pct);
        int stop_at;
        stop_at   = bytes_sent + n_bytes;
        src_idle  = idle_pct;
        rcv_stall <= stall_pct;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 85)
                send_response();
            else
                send_noise();
        end
    endtask

    task automatic test_input_stall();
        src_idle  = 0;
        rcv_stall <= 0;
        fork
            begin
                rcv_hold <= 1'b1;
                repeat (200) @(posedge clk);
                rcv_hold <= 1'b0;
            end
            repeat (25) send_response();
        join
    endtask

    task automatic test_pause_drain();
        src_idle = 0;
        repeat (3) send_response();
        wait_drain();
        repeat (3) send_response();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        out_ch.ready  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_noise();
        test_ok_response();
        test_text_lines();
        test_random_traffic(200, 0, 0);
        test_random_traffic(200, 74, 0);
        test_random_traffic(200, 0, 74);
        test_random_traffic(200, 16, 16);
        test_input_stall();
        test_pause_drain();

        wait_drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: at_response_parser_top.f
hw/rtl/atrp_pkg.sv
hw/rtl/atrp_in_if.sv
hw/rtl/atrp_out_if.sv
hw/rtl/at_response_parser_top.sv
verif/tb_at_response_parser_top.sv
